### sv/sec_pkg.sv
// shared types and request codes for the set equality checker
`timescale 1ns / 1ps
`default_nettype none

package sec_pkg;

	// width of one stored value
	localparam int WORD_W = 32;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic [1:0]               req_t;

	// request codes
	localparam req_t REQ_INS_A = 2'd0;
	localparam req_t REQ_INS_B = 2'd1;
	localparam req_t REQ_CMP   = 2'd2;
	localparam req_t REQ_CLR   = 2'd3;

endpackage

`default_nettype wire

### sv/same_element_set_compare.sv
// top level: two value lists in rams with an order-free set compare
//
// Usage: present an item on req_type and value with start high; it is taken
// at a rising edge where start is high and busy is low. Every item gives one
// result, shown for exactly one cycle with done high, on accepted and
// same_elements. Results cannot be held off by the receiver.
//
// Insert into list A or B and clear: the result appears the cycle after the
// item is taken and busy stays low, so these items can follow each other in
// every cycle. An insert into a full list is refused with accepted low and
// leaves the list unchanged. Compare walks the lists through the single read
// port of each ram. Each key is read first, then the entries of the other
// list are scanned in order, stopping at the first match; a key with no
// match ends the compare. With either list empty the result appears the
// cycle after the item is taken. busy is high for the length of the walk.
//
// Reset clears both fill counts; the ram words are never cleared since only
// entries below a fill count are ever used.
`timescale 1ns / 1ps
`default_nettype none

module same_element_set_compare #(
	parameter int MAX_ITEMS = 64
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire sec_pkg::req_t req_type,
	input  wire sec_pkg::word_t value,
	output logic               done,
	output logic               accepted,
	output logic               same_elements
);

	import sec_pkg::*;

	localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam logic [CW-1:0] FULL = CW'(MAX_ITEMS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_KEY,
		ST_LOAD,
		ST_SCAN
	} state_t;

	state_t            state_q;
	logic [CW-1:0]     cnt_a_q;
	logic [CW-1:0]     cnt_b_q;
	logic [CW-1:0]     i_q;
	logic [CW-1:0]     j_q;
	logic              pass_q;
	logic [WORD_W-1:0] key_q;
	logic              done_q;
	logic              acc_q;
	logic              same_q;

	logic              take;
	logic              we_a;
	logic              we_b;
	logic [AW-1:0]     raddr_a;
	logic [AW-1:0]     raddr_b;
	logic [WORD_W-1:0] rdata_a;
	logic [WORD_W-1:0] rdata_b;
	logic [WORD_W-1:0] src_data;
	logic [WORD_W-1:0] dst_data;
	logic [CW-1:0]     n_src;
	logic [CW-1:0]     n_dst;
	logic [CW-1:0]     i_next;

	// handshake
	assign busy = (state_q != ST_IDLE);
	assign take = start && !busy;

	// insert writes go straight to the ram at the fill count
	assign we_a = take && (req_type == REQ_INS_A) && (cnt_a_q != FULL);
	assign we_b = take && (req_type == REQ_INS_B) && (cnt_b_q != FULL);

	// pass 0 takes keys from A and scans B, pass 1 the other way round
	assign raddr_a  = pass_q ? j_q[AW-1:0] : i_q[AW-1:0];
	assign raddr_b  = pass_q ? i_q[AW-1:0] : j_q[AW-1:0];
	assign src_data = pass_q ? rdata_b : rdata_a;
	assign dst_data = pass_q ? rdata_a : rdata_b;
	assign n_src    = pass_q ? cnt_b_q : cnt_a_q;
	assign n_dst    = pass_q ? cnt_a_q : cnt_b_q;
	assign i_next   = i_q + CW'(1);

	sec_ram #(
		.WIDTH (WORD_W),
		.DEPTH (MAX_ITEMS)
	) u_ram_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (cnt_a_q[AW-1:0]),
		.wdata (value),
		.raddr (raddr_a),
		.rdata (rdata_a)
	);

	sec_ram #(
		.WIDTH (WORD_W),
		.DEPTH (MAX_ITEMS)
	) u_ram_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (cnt_b_q[AW-1:0]),
		.wdata (value),
		.raddr (raddr_b),
		.rdata (rdata_b)
	);

	// key value of the current pass, payload only
	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			key_q <= src_data;
		end
	end

	// control state machine and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_a_q <= '0;
			cnt_b_q <= '0;
			i_q     <= '0;
			j_q     <= '0;
			pass_q  <= 1'b0;
			done_q  <= 1'b0;
			acc_q   <= 1'b0;
			same_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						case (req_type)
							REQ_INS_A: begin
								done_q <= 1'b1;
								same_q <= 1'b0;
								acc_q  <= (cnt_a_q != FULL);
								if (cnt_a_q != FULL) begin
									cnt_a_q <= cnt_a_q + CW'(1);
								end
							end
							REQ_INS_B: begin
								done_q <= 1'b1;
								same_q <= 1'b0;
								acc_q  <= (cnt_b_q != FULL);
								if (cnt_b_q != FULL) begin
									cnt_b_q <= cnt_b_q + CW'(1);
								end
							end
							REQ_CMP: begin
								if ((cnt_a_q == '0) || (cnt_b_q == '0)) begin
									// an empty list matches only another empty one
									done_q <= 1'b1;
									acc_q  <= 1'b1;
									same_q <= (cnt_a_q == '0) && (cnt_b_q == '0);
								end else begin
									pass_q  <= 1'b0;
									i_q     <= '0;
									state_q <= ST_KEY;
								end
							end
							default: begin
								cnt_a_q <= '0;
								cnt_b_q <= '0;
								done_q  <= 1'b1;
								acc_q   <= 1'b1;
								same_q  <= 1'b0;
							end
						endcase
					end
				end
				ST_KEY: begin
					// key read in flight, scan starts at entry zero
					j_q     <= '0;
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					// first scan read in flight
					j_q     <= CW'(1);
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (dst_data == key_q) begin
						if (i_next == n_src) begin
							if (!pass_q) begin
								pass_q  <= 1'b1;
								i_q     <= '0;
								state_q <= ST_KEY;
							end else begin
								done_q  <= 1'b1;
								acc_q   <= 1'b1;
								same_q  <= 1'b1;
								state_q <= ST_IDLE;
							end
						end else begin
							i_q     <= i_next;
							state_q <= ST_KEY;
						end
					end else if (j_q == n_dst) begin
						// key missing from the other list
						done_q  <= 1'b1;
						acc_q   <= 1'b1;
						same_q  <= 1'b0;
						state_q <= ST_IDLE;
					end else begin
						j_q <= j_q + CW'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done          = done_q;
	assign accepted      = acc_q;
	assign same_elements = same_q;

	// results never leave while a compare walk is still running
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	// fill counts stay within the store depth
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_a_q <= FULL) && (cnt_b_q <= FULL))
		else $error("fill count beyond depth");

	// an item other than a compare of two non-empty lists answers next cycle
	a_quick_result: assert property (@(posedge clk) disable iff (!arst_n)
		(take && ((req_type != REQ_CMP) || (cnt_a_q == '0) || (cnt_b_q == '0)))
		|=> done)
		else $error("single cycle item gave no result");

	// a match flag is shown only together with accepted high
	a_same_flag: assert property (@(posedge clk) disable iff (!arst_n)
		same_elements && done |-> accepted)
		else $error("match flag without acceptance");

	// the scan index never passes the length of the scanned list, and the key index stays below the key list length
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (j_q <= n_dst) && (i_q < n_src))
		else $error("scan index out of range");

endmodule

`default_nettype wire

### sv/sec_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module sec_ram #(
	parameter  int WIDTH = 32,
	parameter  int DEPTH = 64,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire
